// File: rtl/core/ebo2_pkg.sv
// ----------------------------------------------------------------------------
// ebo2_pkg
// Shared types, constants and helpers for the second-order edge basis
// evaluator pipeline.
// ----------------------------------------------------------------------------
package ebo2_pkg;

   // default fraction bits of coordinates and results
   localparam int FRAC_BITS_DEF = 16;

   // fixed field widths
   localparam int COORD_W  = 17;
   localparam int PROD_W   = 2 * COORD_W;
   localparam int OUT_W    = 21;
   localparam int SHAPE_W  = 2;
   localparam int EDGE_W   = 3;
   localparam int STATUS_W = 2;

   // element shape codes
   typedef enum logic [SHAPE_W-1:0] {
      SHAPE_LINE  = 2'd0,
      SHAPE_TRI   = 2'd1,
      SHAPE_TET   = 2'd2,
      SHAPE_OTHER = 2'd3
   } shape_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_EDGE  = 2'd1,
      STATUS_BAD_SHAPE = 2'd2
   } status_type;

   // edge numbers, counted from one
   localparam logic [EDGE_W-1:0] EDGE_1 = 3'd1;
   localparam logic [EDGE_W-1:0] EDGE_2 = 3'd2;
   localparam logic [EDGE_W-1:0] EDGE_3 = 3'd3;
   localparam logic [EDGE_W-1:0] EDGE_4 = 3'd4;
   localparam logic [EDGE_W-1:0] EDGE_5 = 3'd5;
   localparam logic [EDGE_W-1:0] EDGE_6 = 3'd6;

   // request control carried down the pipeline
   typedef struct packed {
      shape_type             shape;
      logic [EDGE_W-1:0]     edge_num;
      logic                  rev;
      logic                  perp;
   } ctl_type;

   // coordinates and their pairwise products
   typedef struct packed {
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
      logic [COORD_W-1:0] w;
      logic [PROD_W-1:0]  uu;
      logic [PROD_W-1:0]  vv;
      logic [PROD_W-1:0]  ww;
      logic [PROD_W-1:0]  uv;
      logic [PROD_W-1:0]  uw;
      logic [PROD_W-1:0]  vw;
   } term_type;

   // control for the output formatting stage
   typedef struct packed {
      status_type status;
      logic       rev;
      logic       perp;
   } fmt_ctl_type;

   // width of an exact polynomial sum, with headroom for coefficients and sign
   function automatic int sum_width(input int frac);
      int base;
      base = (2 * frac > PROD_W) ? 2 * frac : PROD_W;
      return base + 8;
   endfunction

endpackage

// File: rtl/core/ebo2_mult.sv
// ----------------------------------------------------------------------------
// ebo2_mult
// Product stage: forms the six pairwise coordinate products and registers
// them with the coordinates and the request control.
// ----------------------------------------------------------------------------
module ebo2_mult (
   input  logic                         clock,
   input  logic                         ld,
   input  logic [ebo2_pkg::COORD_W-1:0] u,
   input  logic [ebo2_pkg::COORD_W-1:0] v,
   input  logic [ebo2_pkg::COORD_W-1:0] w,
   input  ebo2_pkg::ctl_type            ctl,
   output ebo2_pkg::term_type           term,
   output ebo2_pkg::ctl_type            term_ctl
);

   ebo2_pkg::term_type term_ff, term_in;
   ebo2_pkg::ctl_type  ctl_ff;

   // pairwise products, exact
   always_comb begin
      term_in.u  = u;
      term_in.v  = v;
      term_in.w  = w;
      term_in.uu = ebo2_pkg::PROD_W'(u) * ebo2_pkg::PROD_W'(u);
      term_in.vv = ebo2_pkg::PROD_W'(v) * ebo2_pkg::PROD_W'(v);
      term_in.ww = ebo2_pkg::PROD_W'(w) * ebo2_pkg::PROD_W'(w);
      term_in.uv = ebo2_pkg::PROD_W'(u) * ebo2_pkg::PROD_W'(v);
      term_in.uw = ebo2_pkg::PROD_W'(u) * ebo2_pkg::PROD_W'(w);
      term_in.vw = ebo2_pkg::PROD_W'(v) * ebo2_pkg::PROD_W'(w);
   end

   // stage register
   always_ff @(posedge clock) begin
      if (ld) begin
         term_ff <= term_in;
         ctl_ff  <= ctl;
      end
   end

   assign term     = term_ff;
   assign term_ctl = ctl_ff;

endmodule

// File: rtl/core/ebo2_poly.sv
// ----------------------------------------------------------------------------
// ebo2_poly
// Polynomial stage: decodes shape and edge, sums the exact basis polynomials
// with 2*FRAC_BITS fraction bits and registers the three components.
// ----------------------------------------------------------------------------
module ebo2_poly #(
   parameter int FRAC_BITS = ebo2_pkg::FRAC_BITS_DEF,
   parameter int SUM_W     = ebo2_pkg::sum_width(FRAC_BITS)
) (
   input  logic                      clock,
   input  logic                      ld,
   input  ebo2_pkg::term_type        term,
   input  ebo2_pkg::ctl_type         term_ctl,
   output logic signed [SUM_W-1:0]   sum_x,
   output logic signed [SUM_W-1:0]   sum_y,
   output logic signed [SUM_W-1:0]   sum_z,
   output ebo2_pkg::fmt_ctl_type     sum_ctl
);

   localparam logic signed [SUM_W-1:0] K2 = SUM_W'(2);
   localparam logic signed [SUM_W-1:0] K3 = SUM_W'(3);
   localparam logic signed [SUM_W-1:0] K6 = SUM_W'(6);

   logic signed [SUM_W-1:0] uu, vv, ww, uv, uw, vw, lu, lv, lw, one2;
   logic signed [SUM_W-1:0] sx_in, sy_in, sz_in;
   logic signed [SUM_W-1:0] sx_ff, sy_ff, sz_ff;
   ebo2_pkg::fmt_ctl_type   ctl_in, ctl_ff;

   // operands at 2*FRAC_BITS fraction bits
   assign uu   = $signed(SUM_W'(term.uu));
   assign vv   = $signed(SUM_W'(term.vv));
   assign ww   = $signed(SUM_W'(term.ww));
   assign uv   = $signed(SUM_W'(term.uv));
   assign uw   = $signed(SUM_W'(term.uw));
   assign vw   = $signed(SUM_W'(term.vw));
   assign lu   = $signed(SUM_W'(term.u) << FRAC_BITS);
   assign lv   = $signed(SUM_W'(term.v) << FRAC_BITS);
   assign lw   = $signed(SUM_W'(term.w) << FRAC_BITS);
   assign one2 = $signed(SUM_W'(1) << (2 * FRAC_BITS));

   // shape and edge decode, polynomial select
   always_comb begin
      sx_in = '0;
      sy_in = '0;
      sz_in = '0;
      ctl_in.status = ebo2_pkg::STATUS_OK;
      ctl_in.rev    = term_ctl.rev;
      ctl_in.perp   = term_ctl.perp;
      unique case (term_ctl.shape)
         ebo2_pkg::SHAPE_LINE: begin
            if (term_ctl.edge_num == ebo2_pkg::EDGE_1) begin
               sx_in = uu;
            end else begin
               ctl_in.status = ebo2_pkg::STATUS_BAD_EDGE;
            end
         end
         ebo2_pkg::SHAPE_TRI: begin
            unique case (term_ctl.edge_num)
               ebo2_pkg::EDGE_1: begin
                  sx_in = one2 - K6 * lu - K2 * lv + K6 * uu + K6 * uv + vv;
                  sy_in = K3 * uu + K2 * uv - K2 * lu;
               end
               ebo2_pkg::EDGE_2: begin
                  sx_in = K3 * vv + K2 * uv - K2 * lv;
                  sy_in = one2 - K6 * lv - K2 * lu + K6 * uv + uu + K6 * vv;
               end
               ebo2_pkg::EDGE_3: begin
                  sx_in = K2 * uv - vv;
                  sy_in = uu - K2 * uv;
               end
               default: ctl_in.status = ebo2_pkg::STATUS_BAD_EDGE;
            endcase
         end
         ebo2_pkg::SHAPE_TET: begin
            unique case (term_ctl.edge_num)
               ebo2_pkg::EDGE_1: begin
                  sx_in = one2 - K6 * lu - K2 * lv - K2 * lw + K6 * uu + K6 * uv
                        + K6 * uw + vv + K2 * vw + ww;
                  sy_in = K3 * uu + K2 * uv + K2 * uw - K2 * lu;
                  sz_in = sy_in;
               end
               ebo2_pkg::EDGE_2: begin
                  sx_in = K3 * vv + K2 * uv + K2 * vw - K2 * lv;
                  sy_in = one2 - K6 * lv - K2 * lu - K2 * lw + K6 * uv + uu
                        + K2 * uw + K6 * vv + K6 * vw + ww;
                  sz_in = sx_in;
               end
               ebo2_pkg::EDGE_3: begin
                  sx_in = K3 * ww + K2 * uw + K2 * vw - K2 * lw;
                  sy_in = sx_in;
                  sz_in = one2 - K6 * lw - K2 * lu - K2 * lv + K6 * uw + uu
                        + K2 * uv + K6 * vw + vv + K6 * ww;
               end
               ebo2_pkg::EDGE_4: begin
                  sx_in = K2 * uv - vv;
                  sy_in = uu - K2 * uv;
               end
               ebo2_pkg::EDGE_5: begin
                  sx_in = K2 * uw - ww;
                  sz_in = uu - K2 * uw;
               end
               ebo2_pkg::EDGE_6: begin
                  sy_in = K2 * vw - ww;
                  sz_in = vv - K2 * vw;
               end
               default: ctl_in.status = ebo2_pkg::STATUS_BAD_EDGE;
            endcase
         end
         ebo2_pkg::SHAPE_OTHER: begin
            ctl_in.status = ebo2_pkg::STATUS_BAD_SHAPE;
         end
      endcase
      // error results are all zero
      if (ctl_in.status != ebo2_pkg::STATUS_OK) begin
         sx_in = '0;
         sy_in = '0;
         sz_in = '0;
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (ld) begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sz_ff  <= sz_in;
         ctl_ff <= ctl_in;
      end
   end

   assign sum_x   = sx_ff;
   assign sum_y   = sy_ff;
   assign sum_z   = sz_ff;
   assign sum_ctl = ctl_ff;

endmodule

// File: rtl/core/ebo2_fmt.sv
// ----------------------------------------------------------------------------
// ebo2_fmt
// Output stage: negates reversed edges, rotates in perpendicular mode, rounds
// to FRAC_BITS fraction bits and saturates into the result register.
// ----------------------------------------------------------------------------
module ebo2_fmt #(
   parameter int FRAC_BITS = ebo2_pkg::FRAC_BITS_DEF,
   parameter int SUM_W     = ebo2_pkg::sum_width(FRAC_BITS)
) (
   input  logic                                 clock,
   input  logic                                 ld,
   input  logic signed [SUM_W-1:0]              sum_x,
   input  logic signed [SUM_W-1:0]              sum_y,
   input  logic signed [SUM_W-1:0]              sum_z,
   input  ebo2_pkg::fmt_ctl_type                sum_ctl,
   output logic signed [ebo2_pkg::OUT_W-1:0]    vec_x,
   output logic signed [ebo2_pkg::OUT_W-1:0]    vec_y,
   output logic signed [ebo2_pkg::OUT_W-1:0]    vec_z,
   output logic [ebo2_pkg::STATUS_W-1:0]        status
);

   localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((1 << (ebo2_pkg::OUT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1 << (ebo2_pkg::OUT_W - 1)));

   logic signed [SUM_W-1:0]           nx, ny, nz, rx, ry;
   logic signed [ebo2_pkg::OUT_W-1:0] vx_in, vy_in, vz_in;
   logic signed [ebo2_pkg::OUT_W-1:0] vx_ff, vy_ff, vz_ff;
   logic [ebo2_pkg::STATUS_W-1:0]     status_ff;

   // round half up, then clamp to the result range
   function automatic logic signed [ebo2_pkg::OUT_W-1:0] rnd_sat(
      input logic signed [SUM_W-1:0] s
   );
      logic signed [SUM_W-1:0] t;
      logic signed [SUM_W-1:0] q;
      t = s + HALF;
      q = t >>> FRAC_BITS;
      if (q > OUT_MAX) begin
         q = OUT_MAX;
      end else if (q < OUT_MIN) begin
         q = OUT_MIN;
      end
      return q[ebo2_pkg::OUT_W-1:0];
   endfunction

   // orientation and rotation on the exact sums
   always_comb begin
      nx = sum_ctl.rev ? -sum_x : sum_x;
      ny = sum_ctl.rev ? -sum_y : sum_y;
      nz = sum_ctl.rev ? -sum_z : sum_z;
      rx = sum_ctl.perp ? -ny : nx;
      ry = sum_ctl.perp ? nx : ny;
      vx_in = rnd_sat(rx);
      vy_in = rnd_sat(ry);
      vz_in = rnd_sat(nz);
   end

   // result register
   always_ff @(posedge clock) begin
      if (ld) begin
         vx_ff     <= vx_in;
         vy_ff     <= vy_in;
         vz_ff     <= vz_in;
         status_ff <= sum_ctl.status;
      end
   end

   assign vec_x  = vx_ff;
   assign vec_y  = vy_ff;
   assign vec_z  = vz_ff;
   assign status = status_ff;

endmodule

// File: rtl/core/edge_basis_order2_eval_unit.sv
// ----------------------------------------------------------------------------
// edge_basis_order2_eval_unit
// Second-order hierarchical edge basis evaluator for line, triangle and
// tetrahedron elements; one vector result per request.
// ----------------------------------------------------------------------------
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  request | req_valid, req_stall, req_* fields         | in
//  result  | rsp_valid, rsp_stall, rsp_vec_*, rsp_status | out
//
//  four register stages: input, products, sums, result; a request taken into
//  the input register passes the products and sums registers before rsp_valid rises
//  one request per cycle while rsp_stall is low; each stage reloads when it is empty
//  or its successor moves, so stalls only back up through full stages
//  synchronous reset clears the stage valid bits only
//  pipeline holds up to four requests while rsp_stall is high
// ----------------------------------------------------------------------------
module edge_basis_order2_eval_unit #(
   parameter int FRAC_BITS = ebo2_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ebo2_pkg::SHAPE_W-1:0]        req_element_shape,
   input  logic [ebo2_pkg::EDGE_W-1:0]         req_edge_number,
   input  logic [ebo2_pkg::COORD_W-1:0]        req_coord_u,
   input  logic [ebo2_pkg::COORD_W-1:0]        req_coord_v,
   input  logic [ebo2_pkg::COORD_W-1:0]        req_coord_w,
   input  logic                                req_edge_reversed,
   input  logic                                req_perpendicular,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ebo2_pkg::OUT_W-1:0]   rsp_vec_x,
   output logic signed [ebo2_pkg::OUT_W-1:0]   rsp_vec_y,
   output logic signed [ebo2_pkg::OUT_W-1:0]   rsp_vec_z,
   output logic [ebo2_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int SUM_W = ebo2_pkg::sum_width(FRAC_BITS);

   logic in_vld_ff, in_vld_in;
   logic prod_vld_ff, prod_vld_in;
   logic sum_vld_ff, sum_vld_in;
   logic out_vld_ff, out_vld_in;
   logic en_in, en_prod, en_sum, en_out;

   logic [ebo2_pkg::COORD_W-1:0] u_ff, v_ff, w_ff;
   ebo2_pkg::ctl_type            ctl_ff;
   ebo2_pkg::term_type           term;
   ebo2_pkg::ctl_type            term_ctl;
   logic signed [SUM_W-1:0]      sum_x, sum_y, sum_z;
   ebo2_pkg::fmt_ctl_type        sum_ctl;

   // stage enables: load when empty or when the next stage moves
   assign en_out  = !out_vld_ff || !rsp_stall;
   assign en_sum  = !sum_vld_ff || en_out;
   assign en_prod = !prod_vld_ff || en_sum;
   assign en_in   = !in_vld_ff || en_prod;

   assign req_stall = !en_in;
   assign rsp_valid = out_vld_ff;

   // valid bits
   always_comb begin
      in_vld_in   = en_in   ? req_valid   : in_vld_ff;
      prod_vld_in = en_prod ? in_vld_ff   : prod_vld_ff;
      sum_vld_in  = en_sum  ? prod_vld_ff : sum_vld_ff;
      out_vld_in  = en_out  ? sum_vld_ff  : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         prod_vld_ff <= prod_vld_in;
         sum_vld_ff  <= sum_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (en_in) begin
         u_ff            <= req_coord_u;
         v_ff            <= req_coord_v;
         w_ff            <= req_coord_w;
         ctl_ff.shape    <= ebo2_pkg::shape_type'(req_element_shape);
         ctl_ff.edge_num <= req_edge_number;
         ctl_ff.rev      <= req_edge_reversed;
         ctl_ff.perp     <= req_perpendicular;
      end
   end

   // products
   ebo2_mult u_mult (
      .clock    (clock),
      .ld       (en_prod),
      .u        (u_ff),
      .v        (v_ff),
      .w        (w_ff),
      .ctl      (ctl_ff),
      .term     (term),
      .term_ctl (term_ctl)
   );

   // polynomial sums
   ebo2_poly #(
      .FRAC_BITS (FRAC_BITS),
      .SUM_W     (SUM_W)
   ) u_poly (
      .clock    (clock),
      .ld       (en_sum),
      .term     (term),
      .term_ctl (term_ctl),
      .sum_x    (sum_x),
      .sum_y    (sum_y),
      .sum_z    (sum_z),
      .sum_ctl  (sum_ctl)
   );

   // orientation, rounding and saturation
   ebo2_fmt #(
      .FRAC_BITS (FRAC_BITS),
      .SUM_W     (SUM_W)
   ) u_fmt (
      .clock   (clock),
      .ld      (en_out),
      .sum_x   (sum_x),
      .sum_y   (sum_y),
      .sum_z   (sum_z),
      .sum_ctl (sum_ctl),
      .vec_x   (rsp_vec_x),
      .vec_y   (rsp_vec_y),
      .vec_z   (rsp_vec_z),
      .status  (rsp_status)
   );

endmodule

// File: tb/sv/edge_basis_order2_eval_checker.sv
// ----------------------------------------------------------------------------
// edge_basis_order2_eval_checker
// Watches the request and result channels of the edge basis evaluator,
// computes the expected basis vector of every accepted request and compares
// each accepted result, field by field, with the oldest expected vector.
// ----------------------------------------------------------------------------
module edge_basis_order2_eval_checker #(
   parameter int FRAC_BITS = ebo2_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [ebo2_pkg::SHAPE_W-1:0]        req_element_shape,
   input  logic [ebo2_pkg::EDGE_W-1:0]         req_edge_number,
   input  logic [ebo2_pkg::COORD_W-1:0]        req_coord_u,
   input  logic [ebo2_pkg::COORD_W-1:0]        req_coord_v,
   input  logic [ebo2_pkg::COORD_W-1:0]        req_coord_w,
   input  logic                                req_edge_reversed,
   input  logic                                req_perpendicular,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [ebo2_pkg::OUT_W-1:0]   rsp_vec_x,
   input  logic signed [ebo2_pkg::OUT_W-1:0]   rsp_vec_y,
   input  logic signed [ebo2_pkg::OUT_W-1:0]   rsp_vec_z,
   input  logic [ebo2_pkg::STATUS_W-1:0]       rsp_status,
   output int                                  mismatch_count,
   output int                                  vectors_in_flight
);

   timeunit 1ns;
   timeprecision 1ps;

   // one evaluated basis vector
   typedef struct packed {
      logic signed [ebo2_pkg::OUT_W-1:0] x;
      logic signed [ebo2_pkg::OUT_W-1:0] y;
      logic signed [ebo2_pkg::OUT_W-1:0] z;
      ebo2_pkg::status_type              status;
   } basis_vec_type;

   localparam longint UNIT    = longint'(1) <<< FRAC_BITS;
   localparam longint VEC_MAX = (longint'(1) <<< (ebo2_pkg::OUT_W - 1)) - 1;
   localparam longint VEC_MIN = -(longint'(1) <<< (ebo2_pkg::OUT_W - 1));

   basis_vec_type expected_vectors [$];
   int            errors;

   // round to nearest, ties toward plus infinity, then saturate
   function automatic logic signed [ebo2_pkg::OUT_W-1:0] fit_vec(input longint exact);
      longint q;
      q = (exact + (UNIT >>> 1)) >>> FRAC_BITS;
      if (q > VEC_MAX) q = VEC_MAX;
      if (q < VEC_MIN) q = VEC_MIN;
      return q[ebo2_pkg::OUT_W-1:0];
   endfunction

   // exact polynomial sums at 2*FRAC_BITS fraction bits, then orientation
   function automatic basis_vec_type eval_edge_basis(
      input ebo2_pkg::shape_type            shape,
      input logic [ebo2_pkg::EDGE_W-1:0]    edge_num,
      input logic [ebo2_pkg::COORD_W-1:0]   cu,
      input logic [ebo2_pkg::COORD_W-1:0]   cv,
      input logic [ebo2_pkg::COORD_W-1:0]   cw,
      input logic                           rev,
      input logic                           perp
   );
      longint        u, v, w, lu, lv, lw, one2, t;
      longint        s [3];
      basis_vec_type r;
      u = cu;
      v = cv;
      w = cw;
      lu = u * UNIT;
      lv = v * UNIT;
      lw = w * UNIT;
      one2 = UNIT * UNIT;
      s[0] = 0;
      s[1] = 0;
      s[2] = 0;
      r.status = ebo2_pkg::STATUS_OK;
      case (shape)
         ebo2_pkg::SHAPE_LINE: begin
            if (edge_num == ebo2_pkg::EDGE_1) s[0] = u * u;
            else r.status = ebo2_pkg::STATUS_BAD_EDGE;
         end
         ebo2_pkg::SHAPE_TRI: begin
            case (edge_num)
               ebo2_pkg::EDGE_1: begin
                  s[0] = -6 * lu + one2 - 2 * lv + 6 * u * u + 6 * u * v + v * v;
                  s[1] = -2 * lu + 3 * u * u + 2 * u * v;
               end
               ebo2_pkg::EDGE_2: begin
                  s[0] = -2 * lv + 3 * v * v + 2 * u * v;
                  s[1] = -6 * lv + one2 - 2 * lu + 6 * u * v + u * u + 6 * v * v;
               end
               ebo2_pkg::EDGE_3: begin
                  s[0] = 2 * u * v - v * v;
                  s[1] = u * u - 2 * u * v;
               end
               default: r.status = ebo2_pkg::STATUS_BAD_EDGE;
            endcase
         end
         ebo2_pkg::SHAPE_TET: begin
            case (edge_num)
               ebo2_pkg::EDGE_1: begin
                  s[0] = -6 * lu + one2 - 2 * lv - 2 * lw + 6 * u * u + 6 * u * v
                         + 6 * u * w + v * v + 2 * v * w + w * w;
                  s[1] = -2 * lu + 3 * u * u + 2 * u * v + 2 * u * w;
                  s[2] = s[1];
               end
               ebo2_pkg::EDGE_2: begin
                  s[0] = -2 * lv + 3 * v * v + 2 * u * v + 2 * v * w;
                  s[1] = -6 * lv + one2 - 2 * lu - 2 * lw + 6 * u * v + u * u
                         + 2 * u * w + 6 * v * v + 6 * v * w + w * w;
                  s[2] = s[0];
               end
               ebo2_pkg::EDGE_3: begin
                  s[0] = -2 * lw + 3 * w * w + 2 * u * w + 2 * v * w;
                  s[1] = s[0];
                  s[2] = -6 * lw + one2 - 2 * lu - 2 * lv + 6 * u * w + u * u
                         + 2 * u * v + 6 * v * w + v * v + 6 * w * w;
               end
               ebo2_pkg::EDGE_4: begin
                  s[0] = 2 * u * v - v * v;
                  s[1] = u * u - 2 * u * v;
               end
               ebo2_pkg::EDGE_5: begin
                  s[0] = 2 * u * w - w * w;
                  s[2] = u * u - 2 * u * w;
               end
               ebo2_pkg::EDGE_6: begin
                  s[1] = 2 * v * w - w * w;
                  s[2] = v * v - 2 * v * w;
               end
               default: r.status = ebo2_pkg::STATUS_BAD_EDGE;
            endcase
         end
         default: r.status = ebo2_pkg::STATUS_BAD_SHAPE;
      endcase
      // errors give a zero vector, otherwise negate then rotate
      if (r.status != ebo2_pkg::STATUS_OK) begin
         s[0] = 0;
         s[1] = 0;
         s[2] = 0;
      end else begin
         if (rev) begin
            s[0] = -s[0];
            s[1] = -s[1];
            s[2] = -s[2];
         end
         if (perp) begin
            t = s[0];
            s[0] = -s[1];
            s[1] = t;
         end
      end
      r.x = fit_vec(s[0]);
      r.y = fit_vec(s[1]);
      r.z = fit_vec(s[2]);
      return r;
   endfunction

   // result side first, then request side, at every rising edge
   always @(posedge clock) begin
      basis_vec_type exp_vec;
      if (reset) begin
         expected_vectors.delete();
         errors = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_vectors.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected result x=%0d y=%0d z=%0d status=%0d",
                        $time, rsp_vec_x, rsp_vec_y, rsp_vec_z, rsp_status);
            end else begin
               exp_vec = expected_vectors.pop_front();
               if (rsp_vec_x !== exp_vec.x || rsp_vec_y !== exp_vec.y ||
                   rsp_vec_z !== exp_vec.z || rsp_status !== exp_vec.status)
                  errors++;
               if (rsp_vec_x !== exp_vec.x)
                  $display("%0t ns: vec_x expected %0d, got %0d",
                           $time, exp_vec.x, rsp_vec_x);
               if (rsp_vec_y !== exp_vec.y)
                  $display("%0t ns: vec_y expected %0d, got %0d",
                           $time, exp_vec.y, rsp_vec_y);
               if (rsp_vec_z !== exp_vec.z)
                  $display("%0t ns: vec_z expected %0d, got %0d",
                           $time, exp_vec.z, rsp_vec_z);
               if (rsp_status !== exp_vec.status)
                  $display("%0t ns: status expected %0d, got %0d",
                           $time, exp_vec.status, rsp_status);
            end
         end
         if (req_valid && !req_stall)
            expected_vectors.push_back(eval_edge_basis(
               ebo2_pkg::shape_type'(req_element_shape), req_edge_number,
               req_coord_u, req_coord_v, req_coord_w, req_edge_reversed,
               req_perpendicular));
      end
      mismatch_count    <= errors;
      vectors_in_flight <= expected_vectors.size();
   end

endmodule

// File: tb/sv/edge_basis_order2_eval_unit_tb.sv
// ----------------------------------------------------------------------------
// edge_basis_order2_eval_unit_tb
// Drives directed and random basis evaluation requests into the evaluator,
// with random idle gaps on both channels and one long result hold-off that
// backs the pipeline up; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module edge_basis_order2_eval_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                           RANDOM_REQUESTS = 450;
   localparam int                           BURST_REQUESTS  = 60;
   localparam int                           HOLD_OFF_CYCLES = 80;
   localparam int                           CYCLE_LIMIT     = 300000;
   localparam logic [ebo2_pkg::COORD_W-1:0] COORD_ONE       = 17'd65536;
   localparam logic [ebo2_pkg::COORD_W-1:0] COORD_MAX       = 17'h1FFFF;
   localparam logic [ebo2_pkg::COORD_W-1:0] COORD_HALF      = 17'd32768;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [ebo2_pkg::SHAPE_W-1:0]      req_element_shape;
   logic [ebo2_pkg::EDGE_W-1:0]       req_edge_number;
   logic [ebo2_pkg::COORD_W-1:0]      req_coord_u;
   logic [ebo2_pkg::COORD_W-1:0]      req_coord_v;
   logic [ebo2_pkg::COORD_W-1:0]      req_coord_w;
   logic                              req_edge_reversed;
   logic                              req_perpendicular;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [ebo2_pkg::OUT_W-1:0] rsp_vec_x;
   logic signed [ebo2_pkg::OUT_W-1:0] rsp_vec_y;
   logic signed [ebo2_pkg::OUT_W-1:0] rsp_vec_z;
   logic [ebo2_pkg::STATUS_W-1:0]     rsp_status;
   int                                mismatch_count;
   int                                vectors_in_flight;
   int                                cycle_count;
   bit                                hold_off_req;

   edge_basis_order2_eval_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_shape (req_element_shape),
      .req_edge_number   (req_edge_number),
      .req_coord_u       (req_coord_u),
      .req_coord_v       (req_coord_v),
      .req_coord_w       (req_coord_w),
      .req_edge_reversed (req_edge_reversed),
      .req_perpendicular (req_perpendicular),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vec_x         (rsp_vec_x),
      .rsp_vec_y         (rsp_vec_y),
      .rsp_vec_z         (rsp_vec_z),
      .rsp_status        (rsp_status)
   );

   edge_basis_order2_eval_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_shape (req_element_shape),
      .req_edge_number   (req_edge_number),
      .req_coord_u       (req_coord_u),
      .req_coord_v       (req_coord_v),
      .req_coord_w       (req_coord_w),
      .req_edge_reversed (req_edge_reversed),
      .req_perpendicular (req_perpendicular),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vec_x         (rsp_vec_x),
      .rsp_vec_y         (rsp_vec_y),
      .rsp_vec_z         (rsp_vec_z),
      .rsp_status        (rsp_status),
      .mismatch_count    (mismatch_count),
      .vectors_in_flight (vectors_in_flight)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // coordinate: mostly inside the unit range, some above, some corners
   function automatic logic [ebo2_pkg::COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return ebo2_pkg::COORD_W'($urandom_range(0, COORD_ONE));
      if (r < 8) return ebo2_pkg::COORD_W'($urandom_range(0, COORD_MAX));
      if (r < 9) begin
         case ($urandom_range(0, 4))
            0: return '0;
            1: return 17'd1;
            2: return COORD_ONE - 17'd1;
            3: return COORD_ONE;
            default: return COORD_MAX;
         endcase
      end
      return ebo2_pkg::COORD_W'($urandom_range(0, 255));
   endfunction

   // offer one request and wait until it is taken
   task automatic send_request(
      input ebo2_pkg::shape_type          shape,
      input logic [ebo2_pkg::EDGE_W-1:0]  edge_num,
      input logic [ebo2_pkg::COORD_W-1:0] cu,
      input logic [ebo2_pkg::COORD_W-1:0] cv,
      input logic [ebo2_pkg::COORD_W-1:0] cw,
      input logic                         rev,
      input logic                         perp
   );
      @(negedge clock);
      req_valid         <= 1'b1;
      req_element_shape <= shape;
      req_edge_number   <= edge_num;
      req_coord_u       <= cu;
      req_coord_v       <= cv;
      req_coord_w       <= cw;
      req_edge_reversed <= rev;
      req_perpendicular <= perp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid for a number of cycles
   task automatic idle_request(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // result side: random stall and free stretches, one long hold-off
   initial begin
      bit done_hold;
      int len;
      bit stall_now;
      done_hold = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         if (hold_off_req && !done_hold) begin
            done_hold = 1'b1;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            stall_now = $urandom_range(0, 2) == 0;
            if (stall_now) len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                             : $urandom_range(1, 3);
            else len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 8);
            @(negedge clock);
            rsp_stall <= stall_now;
            repeat (len - 1) @(negedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      ebo2_pkg::shape_type         shape;
      logic [ebo2_pkg::EDGE_W-1:0] edge_num;
      int                          max_edge;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_element_shape = '0;
      req_edge_number   = '0;
      req_coord_u       = '0;
      req_coord_v       = '0;
      req_coord_w       = '0;
      req_edge_reversed = 1'b0;
      req_perpendicular = 1'b0;
      hold_off_req      = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // every edge of every shape at ordinary points
      send_request(ebo2_pkg::SHAPE_LINE, ebo2_pkg::EDGE_1, COORD_ONE, '0, '0, 1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_LINE, ebo2_pkg::EDGE_1, COORD_MAX, COORD_MAX, COORD_MAX,
                   1'b1, 1'b0);
      send_request(ebo2_pkg::SHAPE_TRI, ebo2_pkg::EDGE_1, 17'd10000, 17'd20000, '0,
                   1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TRI, ebo2_pkg::EDGE_2, 17'd30000, 17'd5000, '0,
                   1'b1, 1'b0);
      idle_request(pick_gap());
      send_request(ebo2_pkg::SHAPE_TRI, ebo2_pkg::EDGE_3, COORD_HALF, 17'd40000, '0,
                   1'b0, 1'b1);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_1, 17'd1000, 17'd2000, 17'd3000,
                   1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_2, 17'd9000, 17'd8000, 17'd7000,
                   1'b1, 1'b1);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_3, 17'd20000, 17'd15000, 17'd25000,
                   1'b0, 1'b1);
      idle_request(pick_gap());
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_4, COORD_ONE, COORD_ONE, '0,
                   1'b1, 1'b0);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_5, '0, 17'd100, COORD_ONE,
                   1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_6, 17'd4, COORD_ONE, COORD_MAX,
                   1'b1, 1'b1);
      // all-zero and all-max coordinates, saturation in both directions
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_1, '0, '0, '0, 1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_1, COORD_MAX, COORD_MAX, COORD_MAX,
                   1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_1, COORD_MAX, COORD_MAX, COORD_MAX,
                   1'b1, 1'b0);
      send_request(ebo2_pkg::SHAPE_TET, ebo2_pkg::EDGE_2, COORD_MAX, COORD_MAX, COORD_MAX,
                   1'b1, 1'b1);
      send_request(ebo2_pkg::SHAPE_TRI, ebo2_pkg::EDGE_2, COORD_MAX, COORD_MAX, COORD_MAX,
                   1'b0, 1'b1);
      // exact rounding tie: x sum is half a unit step, both signs
      send_request(ebo2_pkg::SHAPE_TRI, ebo2_pkg::EDGE_3, 17'd192, 17'd128, '0, 1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TRI, ebo2_pkg::EDGE_3, 17'd192, 17'd128, '0, 1'b1, 1'b0);
      // bad edge numbers and the unsupported shape
      send_request(ebo2_pkg::SHAPE_LINE, 3'd0, COORD_ONE, COORD_ONE, COORD_ONE, 1'b1, 1'b1);
      send_request(ebo2_pkg::SHAPE_LINE, ebo2_pkg::EDGE_2, COORD_ONE, '0, '0, 1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TRI, ebo2_pkg::EDGE_4, COORD_HALF, COORD_HALF, '0,
                   1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_TRI, 3'd7, COORD_HALF, COORD_HALF, '0, 1'b1, 1'b0);
      send_request(ebo2_pkg::SHAPE_TET, 3'd0, COORD_HALF, COORD_HALF, COORD_HALF,
                   1'b0, 1'b1);
      send_request(ebo2_pkg::SHAPE_TET, 3'd7, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
      send_request(ebo2_pkg::SHAPE_OTHER, ebo2_pkg::EDGE_1, COORD_ONE, COORD_ONE, COORD_ONE,
                   1'b0, 1'b0);
      send_request(ebo2_pkg::SHAPE_OTHER, 3'd0, COORD_MAX, '0, COORD_MAX, 1'b1, 1'b1);

      // random requests, starting with a gapless burst against a held result side
      hold_off_req = 1'b1;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         case ($urandom_range(0, 11))
            0, 1:       shape = ebo2_pkg::SHAPE_LINE;
            2, 3, 4, 5: shape = ebo2_pkg::SHAPE_TRI;
            11:         shape = ebo2_pkg::SHAPE_OTHER;
            default:    shape = ebo2_pkg::SHAPE_TET;
         endcase
         max_edge = (shape == ebo2_pkg::SHAPE_LINE) ? 1 :
                    (shape == ebo2_pkg::SHAPE_TRI) ? 3 : 6;
         if ($urandom_range(0, 19) < 17)
            edge_num = ebo2_pkg::EDGE_W'($urandom_range(1, max_edge));
         else
            edge_num = ebo2_pkg::EDGE_W'($urandom_range(0, 7));
         send_request(shape, edge_num, pick_coord(), pick_coord(), pick_coord(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         if (i >= BURST_REQUESTS) idle_request(pick_gap());
      end
      idle_request(1);

      // drain, then allow the pipeline latency to pass
      while (vectors_in_flight != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
